// ===== rtl/bpg_pkg.sv =====
`timescale 1ns / 1ps

package bpg_pkg;

   // Operation codes carried by a request
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_TRIGGER = 2'd1;
   localparam logic [1:0] OP_STOP    = 2'd2;

   // Pattern codes
   localparam logic [2:0] PAT_OFF        = 3'd0;
   localparam logic [2:0] PAT_SINGLE     = 3'd1;
   localparam logic [2:0] PAT_DOUBLE     = 3'd2;
   localparam logic [2:0] PAT_TRIPLE     = 3'd3;
   localparam logic [2:0] PAT_LONG       = 3'd4;
   localparam logic [2:0] PAT_CONTINUOUS = 3'd5;
   localparam logic [2:0] PAT_ERROR      = 3'd6;

   localparam logic [8:0] ELAPSED_MAX = 9'd511;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_ON       = 2'd1,
      PH_OFF      = 2'd2,
      PH_COMPLETE = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [8:0] elapsed;
      logic [8:0] beep_length;
      logic [1:0] beeps_done;
      logic [1:0] beeps_target;
      logic [2:0] pattern;
   } state_type;

   typedef struct packed {
      logic       buzzer_on;
      logic       busy_res;
      logic [2:0] active_pattern;
   } result_type;

   // Beep length in milliseconds for each pattern
   function automatic logic [8:0] beep_length(input logic [2:0] code);
      logic [8:0] len;
      case (code)
         PAT_SINGLE:     len = 9'd100;
         PAT_DOUBLE:     len = 9'd80;
         PAT_TRIPLE:     len = 9'd60;
         PAT_LONG:       len = 9'd500;
         PAT_CONTINUOUS: len = 9'd200;
         PAT_ERROR:      len = 9'd50;
         default:        len = 9'd0;
      endcase
      return len;
   endfunction

   // Number of on phases per pattern; zero means it never ends
   function automatic logic [1:0] beep_target(input logic [2:0] code);
      logic [1:0] tgt;
      case (code)
         PAT_SINGLE: tgt = 2'd1;
         PAT_DOUBLE: tgt = 2'd2;
         PAT_TRIPLE: tgt = 2'd3;
         PAT_LONG:   tgt = 2'd1;
         PAT_ERROR:  tgt = 2'd3;
         default:    tgt = 2'd0;
      endcase
      return tgt;
   endfunction

endpackage

// ===== rtl/bpg_step.sv =====
`timescale 1ns / 1ps

module bpg_step (
   input  bpg_pkg::state_type  cur,
   input  logic [1:0]          operation,
   input  logic [2:0]          pattern_code,
   output bpg_pkg::state_type  nxt,
   output bpg_pkg::result_type result
);

   logic [8:0] elapsed_inc;
   logic [1:0] done_inc;
   logic       running;

   assign running     = (cur.phase == bpg_pkg::PH_ON) || (cur.phase == bpg_pkg::PH_OFF);
   assign elapsed_inc = (cur.elapsed < bpg_pkg::ELAPSED_MAX) ? cur.elapsed + 9'd1 : cur.elapsed;
   assign done_inc    = cur.beeps_done + 2'd1;

   // Work out the state left by one request
   always_comb begin
      nxt = cur;
      case (operation)
         bpg_pkg::OP_TICK: begin
            if (running) begin
               nxt.elapsed = elapsed_inc;
               if (elapsed_inc >= cur.beep_length) begin
                  if (cur.phase == bpg_pkg::PH_ON) begin
                     nxt.beeps_done = done_inc;
                     if (cur.beeps_target != 2'd0 && done_inc >= cur.beeps_target) begin
                        nxt.phase   = bpg_pkg::PH_COMPLETE;
                        nxt.pattern = bpg_pkg::PAT_OFF;
                     end else begin
                        nxt.phase   = bpg_pkg::PH_OFF;
                        nxt.elapsed = 9'd0;
                     end
                  end else begin
                     nxt.phase   = bpg_pkg::PH_ON;
                     nxt.elapsed = 9'd0;
                  end
               end
            end
         end
         bpg_pkg::OP_TRIGGER: begin
            if (pattern_code == bpg_pkg::PAT_OFF) begin
               nxt.phase   = bpg_pkg::PH_IDLE;
               nxt.pattern = bpg_pkg::PAT_OFF;
            end else if (pattern_code <= bpg_pkg::PAT_ERROR) begin
               nxt.pattern      = pattern_code;
               nxt.beeps_done   = 2'd0;
               nxt.beeps_target = bpg_pkg::beep_target(pattern_code);
               nxt.beep_length  = bpg_pkg::beep_length(pattern_code);
               nxt.phase        = bpg_pkg::PH_ON;
               nxt.elapsed      = 9'd0;
            end
         end
         bpg_pkg::OP_STOP: begin
            nxt.phase   = bpg_pkg::PH_IDLE;
            nxt.pattern = bpg_pkg::PAT_OFF;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // Derive the outputs from the new state
   assign result.buzzer_on      = (nxt.phase == bpg_pkg::PH_ON);
   assign result.busy_res       = (nxt.phase == bpg_pkg::PH_ON) || (nxt.phase == bpg_pkg::PH_OFF);
   assign result.active_pattern = nxt.pattern;

endmodule

// ===== rtl/bpg_skid.sv =====
`timescale 1ns / 1ps

module bpg_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  bpg_pkg::result_type in_data,
   output logic                in_stall,
   output logic                out_valid,
   input  logic                out_stall,
   output bpg_pkg::result_type out_data
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   bpg_pkg::result_type main_ff, main_in;
   bpg_pkg::result_type skid_ff, skid_in;
   logic                accept;
   logic                drain;

   assign in_stall  = skid_valid_ff;
   assign accept    = in_valid && !skid_valid_ff;
   assign drain     = main_valid_ff && !out_stall;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Advance the output slot, park a result in the skid slot on stall
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (drain || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== rtl/buzzer_beep_pattern_generator.sv =====
`timescale 1ns / 1ps

// Buzzer beep pattern generator.
// Request channel (req_): each request is a 1 ms tick, a trigger carrying a
// pattern code, or a stop. A request is taken at a clock edge with req_valid
// high and req_stall low.
// Response channel (rsp_): exactly one response per request, in order,
// giving the buzzer pin level, the busy flag and the active pattern as they
// stand after that request. Taken at an edge with rsp_valid high and
// rsp_stall low.
// Response: each result is registered in the buffer's output slot, or in its
// skid slot on stall. Throughput: one request per cycle with req_stall low;
// the state update is a single pass of counter compares ahead of the buffer.
// Stall: a two-slot output buffer keeps accepting one further request while
// a response waits; req_stall rises only when both slots are full.
// Reset (synchronous, active high): the pattern goes idle, all counters
// clear and no response is pending.

module buzzer_beep_pattern_generator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [2:0] req_pattern_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_buzzer_on,
   output logic       rsp_busy_res,
   output logic [2:0] rsp_active_pattern
);

   bpg_pkg::state_type  state_ff, state_in;
   bpg_pkg::state_type  step_state;
   bpg_pkg::result_type step_result;
   bpg_pkg::result_type rsp_data;
   logic                accept;

   assign accept = req_valid && !req_stall;

   bpg_step u_step (
      .cur          (state_ff),
      .operation    (req_operation),
      .pattern_code (req_pattern_code),
      .nxt          (step_state),
      .result       (step_result)
   );

   // Hold the pattern state unless a request is taken
   assign state_in = accept ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= bpg_pkg::PH_IDLE;
         state_ff.elapsed      <= 9'd0;
         state_ff.beep_length  <= 9'd0;
         state_ff.beeps_done   <= 2'd0;
         state_ff.beeps_target <= 2'd0;
         state_ff.pattern      <= bpg_pkg::PAT_OFF;
      end else begin
         state_ff <= state_in;
      end
   end

   bpg_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (step_result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_buzzer_on      = rsp_data.buzzer_on;
   assign rsp_busy_res       = rsp_data.busy_res;
   assign rsp_active_pattern = rsp_data.active_pattern;

endmodule

// ===== rtl/bpg_checker.sv =====
`timescale 1ns / 1ps

module bpg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_operation,
   input logic [2:0] req_pattern_code,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_buzzer_on,
   input logic       rsp_busy_res,
   input logic [2:0] rsp_active_pattern
);

   // Hold a stalled request
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_operation)
         && $stable(req_pattern_code))
      else $error("stalled request changed");

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_buzzer_on)
         && $stable(rsp_busy_res) && $stable(rsp_active_pattern))
      else $error("stalled response changed");

   // Sound only during a running pattern
   a_on_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_buzzer_on |-> rsp_busy_res)
      else $error("buzzer on while not busy");

   // Name a pattern whenever one runs
   a_busy_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_busy_res |-> rsp_active_pattern != bpg_pkg::PAT_OFF
         && rsp_active_pattern <= bpg_pkg::PAT_ERROR)
      else $error("busy without a valid pattern");

   // Drop the pattern code once idle or finished
   a_idle_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_active_pattern == bpg_pkg::PAT_OFF)
      else $error("pattern code left set while not busy");

endmodule

bind buzzer_beep_pattern_generator bpg_checker u_bpg_checker (.*);
